/* rtl/imh_pkg.sv */
// Package for the indexed min-heap: sizes, operation and status codes.
// No dependencies.
package imh_pkg;
    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 31;
    localparam int POS_BITS = $clog2(CAPACITY + 1);
    localparam int VTX_BITS = 8;
    localparam int NUM_VERTICES = 256;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CHANGE = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [VTX_BITS-1:0] t_vtx;
endpackage

/* rtl/indexed_min_heap.sv */
// Indexed binary min-heap (vertex, key) with key change in place.
// Depends on imh_pkg.
//
// Each transaction is taken when start is high and busy low; one result
// follows on o_valid for one cycle, and the receiver cannot stall it. A
// sequencer walks the heap one level at a time through a key comparator
// shared by sift-up and sift-down. A level of sift-up runs parent read,
// capture, compare and one write; a level of sift-down runs two child reads,
// capture, compare and one write. An operation also has look-up, dispatch,
// final write and result steps. After reset a clearing pass over all 256
// map entries empties the position map; busy is high during reset and
// during that pass.
module indexed_min_heap
    import imh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_vertex_id,
    input  logic [30:0] i_key_value,
    output logic        o_valid,
    output logic [7:0]  o_out_vertex,
    output logic [30:0] o_out_key,
    output logic [1:0]  o_status,
    output logic [8:0]  o_entry_count
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2, S_DISP = 4'd3,
                           S_RD1 = 4'd4, S_RD2 = 4'd5, S_CMP = 4'd6, S_SW1 = 4'd7,
                           S_SW2 = 4'd8, S_DONE = 4'd9, S_ROOT = 4'd10, S_ROOT2 = 4'd11,
                           S_RD3 = 4'd12;

    // memories: heap entries and position map
    t_vtx r_hv [1:CAPACITY];
    t_key r_hk [1:CAPACITY];
    t_pos r_pos [0:NUM_VERTICES-1];

    logic [3:0] r_st;
    t_pos r_cnt, r_p, r_q;
    logic [1:0] r_op, r_status;
    t_vtx r_v, r_ov, r_av, r_bv;
    t_key r_key, r_ok, r_ak, r_bk;
    logic r_up, r_moved, r_lchild;
    logic [7:0] r_clr;

    // memory port control (one heap write and one heap read, one map write and one map read per cycle)
    logic hw_en; t_pos hw_a; t_vtx hw_v; t_key hw_k;
    t_pos hr_a; t_vtx hr_v; t_key hr_k;
    logic pw_en; t_vtx pw_a; t_pos pw_d;
    t_vtx pr_a; t_pos pr_d;

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            r_hv[hw_a] <= hw_v;
            r_hk[hw_a] <= hw_k;
        end
        hr_v <= r_hv[hr_a];
        hr_k <= r_hk[hr_a];
        if (pw_en) r_pos[pw_a] <= pw_d;
        pr_d <= r_pos[pr_a];
    end

    // shared comparator: up asks travelling < parent, down asks child < travelling
    logic lt;
    t_key cmp_a, cmp_b;
    assign cmp_a = r_up ? r_bk : r_ak;
    assign cmp_b = r_up ? r_ak : r_bk;
    assign lt = cmp_b < cmp_a;

    t_pos pdiv;
    assign pdiv = r_p >> 1;

    // sequencer
    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_clr <= '0; r_cnt <= '0;
        end else begin
            case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'hff) r_st <= S_IDLE;
                end
                S_IDLE: if (start) begin
                    r_op <= i_op; r_v <= i_vertex_id; r_key <= i_key_value;
                    r_status <= ST_OK; r_ov <= '0; r_ok <= '0;
                    r_st <= S_LOOK;
                end
                S_LOOK: r_st <= S_DISP;
                S_DISP: begin
                    if (r_op == OP_INSERT || r_op == OP_CHANGE) begin
                        if (pr_d != '0) begin
                            r_p <= pr_d; r_up <= 1'b1; r_moved <= 1'b0;
                            r_av <= r_v; r_ak <= r_key;
                            r_st <= S_RD1;
                        end else if (r_op == OP_CHANGE) begin
                            r_status <= ST_ABSENT; r_st <= S_DONE;
                        end else if (r_cnt >= t_pos'(CAPACITY)) begin
                            r_status <= ST_FULL; r_st <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1; r_p <= r_cnt + 1'b1;
                            r_up <= 1'b1; r_moved <= 1'b1;
                            r_av <= r_v; r_ak <= r_key;
                            r_st <= S_RD1;
                        end
                    end else if (r_cnt == '0) begin
                        r_status <= ST_EMPTY; r_st <= S_DONE;
                    end else r_st <= S_ROOT;
                end
                S_ROOT: r_st <= S_ROOT2;
                S_ROOT2: begin
                    r_ov <= hr_v; r_ok <= hr_k;
                    if (r_op == OP_PEEK) r_st <= S_DONE;
                    else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_p <= t_pos'(1); r_up <= 1'b0; r_st <= S_RD3;
                    end
                end
                // last entry read, becomes the sinking entry at the root
                S_RD3: begin
                    r_av <= hr_v; r_ak <= hr_k;
                    r_st <= S_RD1;
                    if (r_cnt == '0) r_st <= S_DONE;
                end
                S_RD1: begin
                    // up: read parent; down: read left child
                    if (r_up) begin
                        if (r_p <= t_pos'(1)) begin
                            if (r_moved) r_st <= S_SW2;
                            else begin r_up <= 1'b0; r_st <= S_RD1; end
                        end else r_st <= S_RD2;
                    end else begin
                        if ({r_p, 1'b0} > {1'b0, r_cnt}) r_st <= S_SW2;
                        else begin r_lchild <= 1'b1; r_st <= S_RD2; end
                    end
                end
                // capture parent, or left child then the smaller of the two
                S_RD2: begin
                    if (r_up) begin
                        r_bv <= hr_v; r_bk <= hr_k;
                        r_st <= S_CMP;
                    end else if (r_lchild) begin
                        r_bv <= hr_v; r_bk <= hr_k;
                        r_q <= {r_p[POS_BITS-2:0], 1'b0};
                        if ({r_p, 1'b1} <= {1'b0, r_cnt}) begin
                            r_lchild <= 1'b0; r_st <= S_RD2;
                        end else r_st <= S_CMP;
                    end else begin
                        // right child only wins when strictly smaller
                        if (hr_k < r_bk) begin
                            r_bv <= hr_v; r_bk <= hr_k;
                            r_q <= {r_p[POS_BITS-2:0], 1'b1};
                        end
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (lt) r_st <= S_SW1;
                    else if (r_up && !r_moved) begin
                        r_up <= 1'b0; r_st <= S_RD1;
                    end else r_st <= S_SW2;
                end
                // move the other entry into the hole at p
                S_SW1: begin
                    r_p <= r_up ? pdiv : r_q;
                    if (r_up) r_moved <= 1'b1;
                    r_st <= S_RD1;
                end
                // place the travelling entry at its final slot
                S_SW2: r_st <= S_DONE;
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_out_vertex <= r_ov; o_out_key <= r_ok; o_status <= r_status;
                    o_entry_count <= 9'(r_cnt);
                    r_lchild <= 1'b0; r_q <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // memory addressing per state
    always_comb begin
        hw_en = 1'b0; hw_a = r_p; hw_v = r_av; hw_k = r_ak;
        hr_a = r_p; pw_en = 1'b0; pw_a = r_av; pw_d = r_p; pr_a = r_v;
        case (r_st)
            S_CLEAR: begin pw_en = 1'b1; pw_a = r_clr; pw_d = '0; end
            S_ROOT: hr_a = t_pos'(1);
            S_ROOT2: begin
                hr_a = r_cnt;
                pw_en = (r_op == OP_REMOVE); pw_a = hr_v; pw_d = '0;
            end
            S_RD1: hr_a = r_up ? pdiv : {r_p[POS_BITS-2:0], 1'b0};
            S_RD2: hr_a = {r_p[POS_BITS-2:0], 1'b1};
            S_SW1: begin
                hw_en = 1'b1; hw_v = r_bv; hw_k = r_bk;
                pw_en = 1'b1; pw_a = r_bv; pw_d = r_p;
            end
            S_SW2: begin hw_en = 1'b1; pw_en = 1'b1; end
            default: ;
        endcase
    end

    assign busy = (r_st != S_IDLE) || !i_rst_n;

    // checks
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_pos'(CAPACITY)) else $error("count above capacity");
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back to back results");
    a_busy_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE) |=> o_valid) else $error("result lost");
endmodule
